@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  `ASSERT_PROP(lbl, clk, rst_n, !(expr), msg)
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

@@ hdl/fdl_pkg.sv @@
`default_nettype none

package fdl_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_TGT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_TGT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FB_TGT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_LEVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_TIME  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_FB    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_LP    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_HP    = 3'd7;
  localparam int CFG_DATA_W = 24;

  // Reset values of the registers
  localparam logic [15:0] LEVEL_TGT_RST  = 16'd0;
  localparam logic [23:0] DELAY_TGT_RST  = 24'd256;
  localparam logic [15:0] FB_TGT_RST     = 16'd0;
  localparam logic [15:0] COEF_LEVEL_RST = 16'd69;
  localparam logic [15:0] COEF_TIME_RST  = 16'd26;
  localparam logic [15:0] COEF_FB_RST    = 16'd43;
  localparam logic [15:0] COEF_LP_RST    = 16'd19520;
  localparam logic [15:0] COEF_HP_RST    = 16'd771;

  // Gain operand of the shared multiply unit (nonnegative, signed form)
  localparam int MUL_A_W = 18;

  // Delay memory port controls
  typedef struct packed {
    logic rd;
    logic wr;
  } mem_ctl_t;

endpackage

`default_nettype wire

@@ hdl/feedback_delay_line_effect.sv @@
// Feedback echo with a linearly interpolated delay tap. Each accepted sample
// is worked through in full before the next one is accepted: one shared
// multiply unit walks the smoother updates, the interpolation, the two
// feedback filters and the gain stages in sequence, and the delay memory
// gives one read per cycle, so the two tap words are fetched one after the
// other. The result sits in an output register, so a stalled result does not
// hold off the next sample until its last cycle. The delay memory needs no
// clearing pass after reset: the wrap flag and write pointer tell which
// entries were written; others read as zero. The user must write configuration
// only while idle; the block does not enforce it. Smoothers glide to new targets.
`default_nettype none
`include "assert_macros.svh"

module feedback_delay_line_effect #(
  parameter int DELAY_DEPTH = 65536,
  parameter int SAMPLE_BITS = 24,
  parameter int ENABLE_COEF = 342
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // configuration
  input  wire logic                                   cfg_we_i,
  input  wire logic [fdl_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  wire logic [fdl_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  // input words
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0]          sample_in_i,
  input  wire logic                                   enabled_i,
  // output words
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]               sample_out_o
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int SW = SAMPLE_BITS;
  localparam int DW = (SW + 18 > 42) ? SW + 18 : 42;
  localparam int RW = DW + 3;
  localparam int CW = (AW + 9 > 25) ? AW + 9 : 25;
  localparam int PW = AW + 9;
  localparam int AMW = fdl_pkg::MUL_A_W;

  localparam logic [CW-1:0] DMIN = CW'(256);
  localparam logic [CW-1:0] DMAX = CW'((DELAY_DEPTH - 2) * 256);
  localparam logic [PW-1:0] SPAN = PW'(DELAY_DEPTH * 256);
  localparam logic [AW-1:0] LAST = AW'(DELAY_DEPTH - 1);
  localparam logic signed [RW-1:0] SMAX = {{(RW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [RW-1:0] SMIN = {{(RW-SW+1){1'b1}}, {(SW-1){1'b0}}};

  // Sequencer states
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_DLY  = 5'd1;   // delay smoother multiply
  localparam logic [4:0] ST_EN   = 5'd2;   // enable smoother multiply
  localparam logic [4:0] ST_LVL  = 5'd3;   // level smoother, clamp delay
  localparam logic [4:0] ST_FB   = 5'd4;   // feedback smoother, read position
  localparam logic [4:0] ST_ADDR = 5'd5;   // tap addresses
  localparam logic [4:0] ST_RDA  = 5'd6;   // read first tap word
  localparam logic [4:0] ST_RDB  = 5'd7;   // read second tap word
  localparam logic [4:0] ST_INTP = 5'd8;   // interpolation multiply
  localparam logic [4:0] ST_TAP  = 5'd9;
  localparam logic [4:0] ST_HPM  = 5'd10;
  localparam logic [4:0] ST_HPA  = 5'd11;
  localparam logic [4:0] ST_HPD  = 5'd12;
  localparam logic [4:0] ST_LPM  = 5'd13;
  localparam logic [4:0] ST_LPA  = 5'd14;  // lowpass update, wet level mult
  localparam logic [4:0] ST_FBM  = 5'd15;  // feedback gain multiply
  localparam logic [4:0] ST_WR   = 5'd16;  // write back, enable gain multiply
  localparam logic [4:0] ST_OUT  = 5'd17;

  function automatic logic signed [SW-1:0] sat_f(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] r;
    r = v;
    if (v > SMAX) r = SMAX;
    if (v < SMIN) r = SMIN;
    return r[SW-1:0];
  endfunction

  // Configuration registers
  logic [15:0] lt_q, ft_q, cl_q, ctm_q, cf_q, clp_q, chp_q;
  logic [23:0] dt_q;

  // Control and filter state
  logic [4:0]             st_q;
  logic signed [32:0]     en_q;
  logic signed [33:0]     lvl_q, fb_q;
  logic signed [41:0]     dly_q;
  logic signed [DW-1:0]   hplp_q, lp_q;
  logic [AW-1:0]          wp_q;
  logic                   wrap_q;
  logic                   out_valid_q;

  // Per-sample payload
  logic signed [SW-1:0]   x_q;
  logic                   enb_q;
  logic [CW-1:0]          dc_q;
  logic [PW-1:0]          pos_q;
  logic [AW-1:0]          ia_q, ib_q;
  logic [7:0]             frac_q;
  logic                   vld_q;
  logic signed [SW-1:0]   a_q, tap_q;
  logic signed [SW:0]     hp_q, wet_q;
  logic signed [SW-1:0]   out_q;

  logic                   mul_go;
  logic signed [AMW-1:0]  mul_a;
  logic signed [DW-1:0]   mul_d;
  logic signed [RW-1:0]   mul_res;
  fdl_pkg::mem_ctl_t      mem_ctl;
  logic [AW-1:0]          raddr;
  logic [SW-1:0]          rdata;
  logic signed [SW-1:0]   rd_val;
  logic signed [SW-1:0]   fbin;
  logic [CW-1:0]          dext, dc;
  logic [PW-1:0]          praw;
  logic                   in_acc, out_free;

  assign in_acc   = in_valid_i && (st_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign rd_val   = vld_q ? $signed(rdata) : '0;
  assign fbin     = sat_f(RW'(x_q) + (mul_res >>> 16));

  // Delay clamp and read position
  assign dext = CW'(dly_q[39:16]);
  assign dc   = (dext < DMIN) ? DMIN : ((dext > DMAX) ? DMAX : dext);
  assign praw = {wp_q, 8'd0} + SPAN - PW'(dc_q);

  // Operand select for the shared multiply unit
  always_comb begin
    mul_go = 1'b1;
    mul_a  = '0;
    mul_d  = '0;
    case (st_q)
      ST_DLY: begin
        mul_a = AMW'(ctm_q);
        mul_d = $signed({{(DW-40){1'b0}}, dt_q, 16'd0}) - DW'(dly_q);
      end
      ST_EN: begin
        mul_a = AMW'(ENABLE_COEF);
        mul_d = $signed({{(DW-32){1'b0}}, enb_q, 31'd0}) - DW'(en_q);
      end
      ST_LVL: begin
        mul_a = AMW'(cl_q);
        mul_d = $signed({{(DW-32){1'b0}}, lt_q, 16'd0}) - DW'(lvl_q);
      end
      ST_FB: begin
        mul_a = AMW'(cf_q);
        mul_d = $signed({{(DW-32){1'b0}}, ft_q, 16'd0}) - DW'(fb_q);
      end
      ST_INTP: begin
        mul_a = AMW'(frac_q);
        mul_d = (DW'(rd_val) - DW'(a_q)) <<< 16;
      end
      ST_HPM: begin
        mul_a = AMW'(chp_q);
        mul_d = (DW'(tap_q) <<< 16) - hplp_q;
      end
      ST_LPM: begin
        mul_a = AMW'(clp_q);
        mul_d = (DW'(hp_q) <<< 16) - lp_q;
      end
      ST_LPA: begin
        mul_a = AMW'(lvl_q[32:16]);
        mul_d = DW'(tap_q) <<< 16;
      end
      ST_FBM: begin
        mul_a = AMW'(fb_q[32:16]);
        mul_d = $signed({lp_q[DW-1:16], 16'd0});
      end
      ST_WR: begin
        mul_a = $signed(en_q[32:15]);
        mul_d = DW'(wet_q) <<< 16;
      end
      default: begin
        mul_go = 1'b0;
      end
    endcase
  end

  fdl_mulq #(
    .DW(DW)
  ) u_mulq (
    .clk_i (clk_i),
    .go_i  (mul_go),
    .a_i   (mul_a),
    .d_i   (mul_d),
    .res_o (mul_res)
  );

  // Delay memory port
  always_comb begin
    mem_ctl.rd = (st_q == ST_RDA) || (st_q == ST_RDB);
    mem_ctl.wr = (st_q == ST_WR);
  end
  assign raddr = (st_q == ST_RDA) ? ia_q : ib_q;

  fdl_dmem #(
    .DEPTH(DELAY_DEPTH),
    .AW   (AW),
    .SW   (SW)
  ) u_dmem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (wp_q),
    .wdata_i (fbin),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Control state, config and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q        <= fdl_pkg::LEVEL_TGT_RST;
      dt_q        <= fdl_pkg::DELAY_TGT_RST;
      ft_q        <= fdl_pkg::FB_TGT_RST;
      cl_q        <= fdl_pkg::COEF_LEVEL_RST;
      ctm_q       <= fdl_pkg::COEF_TIME_RST;
      cf_q        <= fdl_pkg::COEF_FB_RST;
      clp_q       <= fdl_pkg::COEF_LP_RST;
      chp_q       <= fdl_pkg::COEF_HP_RST;
      st_q        <= ST_IDLE;
      en_q        <= '0;
      lvl_q       <= $signed({2'b00, fdl_pkg::LEVEL_TGT_RST, 16'd0});
      fb_q        <= $signed({2'b00, fdl_pkg::FB_TGT_RST, 16'd0});
      dly_q       <= $signed({2'b00, fdl_pkg::DELAY_TGT_RST, 16'd0});
      hplp_q      <= '0;
      lp_q        <= '0;
      wp_q        <= '0;
      wrap_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          fdl_pkg::REG_LEVEL_TGT:  lt_q  <= cfg_data_i[15:0];
          fdl_pkg::REG_DELAY_TGT:  dt_q  <= cfg_data_i;
          fdl_pkg::REG_FB_TGT:     ft_q  <= cfg_data_i[15:0];
          fdl_pkg::REG_COEF_LEVEL: cl_q  <= cfg_data_i[15:0];
          fdl_pkg::REG_COEF_TIME:  ctm_q <= cfg_data_i[15:0];
          fdl_pkg::REG_COEF_FB:    cf_q  <= cfg_data_i[15:0];
          fdl_pkg::REG_COEF_LP:    clp_q <= cfg_data_i[15:0];
          fdl_pkg::REG_COEF_HP:    chp_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end

      // output word: a new result replaces one taken in the same cycle
      if (st_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      // sequencer
      case (st_q)
        ST_IDLE: if (in_acc) st_q <= ST_DLY;
        ST_EN: begin
          dly_q <= dly_q + 42'(mul_res);
          st_q  <= ST_LVL;
        end
        ST_LVL: begin
          en_q <= en_q + 33'(mul_res);
          st_q <= ST_FB;
        end
        ST_FB: begin
          lvl_q <= lvl_q + 34'(mul_res);
          st_q  <= ST_ADDR;
        end
        ST_ADDR: begin
          fb_q <= fb_q + 34'(mul_res);
          st_q <= ST_RDA;
        end
        ST_HPA: begin
          hplp_q <= hplp_q + DW'(mul_res);
          st_q   <= ST_HPD;
        end
        ST_LPA: begin
          lp_q <= lp_q + DW'(mul_res);
          st_q <= ST_FBM;
        end
        ST_WR: begin
          if (wp_q == LAST) begin
            wp_q   <= '0;
            wrap_q <= 1'b1;
          end else begin
            wp_q <= wp_q + 1'b1;
          end
          st_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            st_q <= ST_IDLE;
          end
        end
        default: begin
          st_q <= st_q + 5'd1;
        end
      endcase
    end
  end

  // Per-sample datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q   <= sample_in_i;
      enb_q <= enabled_i;
    end
    if (st_q == ST_LVL) dc_q <= dc;
    if (st_q == ST_FB) pos_q <= (praw >= SPAN) ? praw - SPAN : praw;
    if (st_q == ST_ADDR) begin
      ia_q   <= pos_q[AW+7:8];
      ib_q   <= (pos_q[AW+7:8] == LAST) ? '0 : pos_q[AW+7:8] + 1'b1;
      frac_q <= pos_q[7:0];
    end
    // entries never written since reset read as zero
    if (mem_ctl.rd) vld_q <= wrap_q || (raddr < wp_q);
    if (st_q == ST_RDB) a_q <= rd_val;
    if (st_q == ST_TAP) tap_q <= SW'(RW'(a_q) + (mul_res >>> 8));
    if (st_q == ST_HPD) hp_q <= (SW+1)'(DW'(tap_q) - (hplp_q >>> 16));
    if (st_q == ST_FBM) wet_q <= (SW+1)'(mul_res >>> 16);
    if (st_q == ST_OUT && out_free) out_q <= sat_f(RW'(x_q) + (mul_res >>> 16));
  end

  assign in_stall_o   = (st_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

  // Checks
  `ASSERT_NEVER(a_mem_rw_overlap, clk_i, rst_ni, mem_ctl.rd && mem_ctl.wr, "read and write overlap")
  `ASSERT_PROP(a_out_from_done, clk_i, rst_ni, $rose(out_valid_q) |-> $past(st_q) == ST_OUT, "result without finish")
  `ASSERT_PROP(a_wp_once, clk_i, rst_ni, (st_q != ST_WR) |=> $stable(wp_q), "write pointer moved outside write back")
  `ASSERT_PROP(a_delay_clamp, clk_i, rst_ni, (st_q == ST_FB) |-> (dc_q >= DMIN) && (dc_q <= DMAX), "delay out of range")

endmodule

`default_nettype wire

@@ hdl/fdl_mulq.sv @@
`default_nettype none

// Shared multiply unit: res = floor(a * d / 65536) for a >= 0.
// d is split into a signed high part and an unsigned low 16 bits; both
// partial products are registered, the sum follows on the register outputs.
module fdl_mulq #(
  parameter int DW = 42
) (
  input  wire logic                              clk_i,
  input  wire logic                              go_i,
  input  wire logic signed [fdl_pkg::MUL_A_W-1:0] a_i,
  input  wire logic signed [DW-1:0]              d_i,
  output logic signed [DW+2:0]                   res_o
);

  localparam int HW = fdl_pkg::MUL_A_W + DW - 16;
  localparam int LW = fdl_pkg::MUL_A_W + 16;

  logic signed [HW-1:0] hi_q;
  logic [LW-1:0]        lo_q;
  logic signed [DW-17:0] d_hi;

  assign d_hi = d_i[DW-1:16];

  // Partial products, held while no new operation is issued
  always_ff @(posedge clk_i) begin
    if (go_i) begin
      hi_q <= a_i * d_hi;
      lo_q <= LW'($unsigned(a_i)) * LW'(d_i[15:0]);
    end
  end

  assign res_o = (DW+3)'(hi_q) + $signed({1'b0, lo_q[LW-1:16]});

endmodule

`default_nettype wire

@@ hdl/fdl_dmem.sv @@
`default_nettype none

// Circular delay memory: one write and one registered read per cycle.
module fdl_dmem #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16,
  parameter int SW    = 24
) (
  input  wire logic              clk_i,
  input  wire fdl_pkg::mem_ctl_t ctl_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [SW-1:0]     wdata_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic [SW-1:0]          rdata_o
);

  logic [SW-1:0] mem_q [DEPTH];
  logic [SW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctl_i.rd) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sim/tb_feedback_delay_line_effect.sv @@
`timescale 1ns / 100ps

module tb_feedback_delay_line_effect;

  localparam int DEPTH    = 65536;
  localparam int SBITS    = 24;
  localparam int EN_COEF  = 342;
  localparam longint SMAX = (64'sd1 <<< (SBITS - 1)) - 1;
  localparam longint SMIN = -(64'sd1 <<< (SBITS - 1));
  localparam int SETTLE   = 60;

  typedef struct packed {
    logic signed [SBITS-1:0] sample;
    logic                    en;
  } word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [fdl_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [fdl_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [SBITS-1:0] sample_in_i = '0;
  logic enabled_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  logic signed [SBITS-1:0] sample_out_o;

  feedback_delay_line_effect uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .sample_in_i(sample_in_i), .enabled_i(enabled_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .sample_out_o(sample_out_o)
  );

  always #4 clk_i = ~clk_i;

  // echo model: registers and state
  longint lvl_tgt, dly_tgt, fb_tgt, c_lvl, c_time, c_fb, c_lp, c_hp;
  longint echo_mem [DEPTH];
  longint wr_ptr, lvl_z, dly_z, fb_z, en_z, hp_lp_z, lp_z;

  word_t                   word_q[$];
  logic signed [SBITS-1:0] expected_out_q[$];
  int  mismatches = 0;
  bit  quiet = 1'b0;
  bit  hold = 1'b0;
  bit  hold_go = 1'b0;

  function automatic longint clip(longint v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  // one-pole step, floor(c * d / 65536)
  function automatic longint pole(longint c, longint d);
    return (c * d) >>> 16;
  endfunction

  task automatic echo_reset();
    lvl_tgt = fdl_pkg::LEVEL_TGT_RST; dly_tgt = fdl_pkg::DELAY_TGT_RST;
    fb_tgt = fdl_pkg::FB_TGT_RST;
    c_lvl = fdl_pkg::COEF_LEVEL_RST; c_time = fdl_pkg::COEF_TIME_RST;
    c_fb = fdl_pkg::COEF_FB_RST; c_lp = fdl_pkg::COEF_LP_RST;
    c_hp = fdl_pkg::COEF_HP_RST;
    foreach (echo_mem[i]) echo_mem[i] = 0;
    wr_ptr = 0;
    lvl_z = lvl_tgt <<< 16; dly_z = dly_tgt <<< 16; fb_z = fb_tgt <<< 16;
    en_z = 0; hp_lp_z = 0; lp_z = 0;
  endtask

  task automatic echo_predict(word_t w);
    longint x, et, d, pos, a, b, tap, hp, dark, fbin, wet, ia, ib, frac;
    x = longint'(w.sample);
    et = w.en ? (64'sd1 <<< 31) : 0;
    en_z  += pole(EN_COEF, et - en_z);
    lvl_z += pole(c_lvl, (lvl_tgt <<< 16) - lvl_z);
    dly_z += pole(c_time, (dly_tgt <<< 16) - dly_z);
    fb_z  += pole(c_fb, (fb_tgt <<< 16) - fb_z);
    d = dly_z >>> 16;
    if (d < 256) d = 256;
    if (d > longint'(DEPTH - 2) * 256) d = longint'(DEPTH - 2) * 256;
    pos = wr_ptr * 256 - d;
    if (pos < 0) pos += longint'(DEPTH) * 256;
    ia = (pos >>> 8) % DEPTH;
    frac = pos & 255;
    ib = (ia + 1 >= DEPTH) ? 0 : ia + 1;
    a = echo_mem[ia];
    b = echo_mem[ib];
    tap = a + (((b - a) * frac) >>> 8);
    hp_lp_z += pole(c_hp, tap * 65536 - hp_lp_z);
    hp = tap - (hp_lp_z >>> 16);
    lp_z += pole(c_lp, hp * 65536 - lp_z);
    dark = lp_z >>> 16;
    fbin = clip(x + ((dark * (fb_z >>> 16)) >>> 16));
    echo_mem[wr_ptr] = fbin;
    wr_ptr = (wr_ptr + 1 >= DEPTH) ? 0 : wr_ptr + 1;
    wet = (tap * (lvl_z >>> 16)) >>> 16;
    wet = (wet * (en_z >>> 15)) >>> 16;
    expected_out_q.push_back(SBITS'(clip(x + wet)));
  endtask

  // sender: accepted word feeds the model, then a gap, then the next word
  int send_gap = 0;
  always @(posedge clk_i) begin
    bit nv;
    word_t w;
    nv = in_valid_i;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        echo_predict('{sample: sample_in_i, en: enabled_i});
        nv = 1'b0;
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (word_q.size() > 0) begin
          w = word_q.pop_front();
          sample_in_i <= w.sample;
          enabled_i <= w.en;
          nv = 1'b1;
          send_gap <= quiet ? 0 : $urandom_range(0, 5);
        end
      end
    end
    in_valid_i <= nv;
  end

  // receiver: compare each accepted word, then draw a stall
  int recv_gap = 0;
  always @(posedge clk_i) begin
    int g;
    g = recv_gap;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_out_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output word %0d", sample_out_o);
        end else begin
          if (sample_out_o !== expected_out_q[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("sample_out mismatch: expected %0d actual %0d",
                       expected_out_q[0], sample_out_o);
          end
          void'(expected_out_q.pop_front());
        end
        g = quiet ? 0 : $urandom_range(0, 5);
      end else if (g > 0) begin
        g--;
      end
    end
    recv_gap <= g;
    out_stall_i <= !rst_ni || hold || (g > 0);
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic reg_write(logic [fdl_pkg::CFG_IDX_W-1:0] idx, longint val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[fdl_pkg::CFG_DATA_W-1:0];
    case (idx)
      fdl_pkg::REG_LEVEL_TGT:  lvl_tgt = val & 16'hFFFF;
      fdl_pkg::REG_DELAY_TGT:  dly_tgt = val & 24'hFFFFFF;
      fdl_pkg::REG_FB_TGT:     fb_tgt = val & 16'hFFFF;
      fdl_pkg::REG_COEF_LEVEL: c_lvl = val & 16'hFFFF;
      fdl_pkg::REG_COEF_TIME:  c_time = val & 16'hFFFF;
      fdl_pkg::REG_COEF_FB:    c_fb = val & 16'hFFFF;
      fdl_pkg::REG_COEF_LP:    c_lp = val & 16'hFFFF;
      default:                 c_hp = val & 16'hFFFF;
    endcase
  endtask

  task automatic reg_done();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    wait (word_q.size() == 0 && !in_valid_i && expected_out_q.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic word_t rand_word(bit en_run);
    word_t w;
    case ($urandom_range(0, 5))
      0, 1: w.sample = SBITS'($urandom);
      2:    w.sample = SBITS'($signed($urandom_range(0, 8191)) - 4096);
      3:    w.sample = $urandom_range(0, 1) ? SBITS'(SMAX) : SBITS'(SMIN);
      4:    w.sample = '0;
      default: w.sample = $signed(24'($urandom)) >>> $urandom_range(0, 12);
    endcase
    w.en = ($urandom_range(0, 9) == 0) ? ~en_run : en_run;
    return w;
  endfunction

  task automatic random_phase(int n);
    bit en_run;
    en_run = $urandom_range(0, 1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 39) == 0) en_run = ~en_run;
      if (i % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
      word_q.push_back(rand_word(en_run));
    end
    drain();
    quiet = 1'b0;
  endtask

  initial begin
    echo_reset();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset settings, field extremes, enable edges
    word_q.push_back('{sample: SBITS'(SMAX), en: 1'b1});
    word_q.push_back('{sample: SBITS'(SMIN), en: 1'b1});
    word_q.push_back('{sample: '0, en: 1'b0});
    word_q.push_back('{sample: 24'sd1, en: 1'b1});
    word_q.push_back('{sample: -24'sd1, en: 1'b0});
    drain();

    // three-quarter wet level, full feedback, shortest delay, fast smoothers: saturation
    reg_write(fdl_pkg::REG_LEVEL_TGT, 49152);
    reg_write(fdl_pkg::REG_FB_TGT, 65535);
    reg_write(fdl_pkg::REG_DELAY_TGT, 256);
    reg_write(fdl_pkg::REG_COEF_LEVEL, 65535);
    reg_write(fdl_pkg::REG_COEF_FB, 65535);
    reg_write(fdl_pkg::REG_COEF_TIME, 65535);
    reg_write(fdl_pkg::REG_COEF_LP, 65535);
    reg_write(fdl_pkg::REG_COEF_HP, 0);
    reg_done();
    for (int i = 0; i < 10; i++)
      word_q.push_back('{sample: (i % 2) ? SBITS'(SMIN) : SBITS'(SMAX), en: 1'b1});
    drain();

    // delay at the upper bound of the clamp range; frozen smoothers hold
    reg_write(fdl_pkg::REG_DELAY_TGT, 16776704);
    reg_done();
    for (int i = 0; i < 4; i++) word_q.push_back('{sample: 24'sd4096, en: 1'b1});
    drain();
    reg_write(fdl_pkg::REG_COEF_LEVEL, 0);
    reg_write(fdl_pkg::REG_COEF_FB, 0);
    reg_write(fdl_pkg::REG_COEF_TIME, 0);
    reg_write(fdl_pkg::REG_COEF_LP, 0);
    reg_write(fdl_pkg::REG_LEVEL_TGT, 0);
    reg_done();
    for (int i = 0; i < 4; i++) word_q.push_back('{sample: -24'sd4096, en: 1'b0});
    drain();

    // random phases over several settings, short fractional delays mostly
    for (int p = 0; p < 6; p++) begin
      reg_write(fdl_pkg::REG_LEVEL_TGT, (p == 1) ? 49152 : $urandom_range(0, 49152));
      reg_write(fdl_pkg::REG_DELAY_TGT, (p == 5) ? 16776704 : $urandom_range(256, 60 * 256));
      reg_write(fdl_pkg::REG_FB_TGT, (p == 2) ? 65535 : $urandom_range(0, 65535));
      reg_write(fdl_pkg::REG_COEF_LEVEL, (p == 3) ? 65535 : $urandom_range(0, 65535));
      reg_write(fdl_pkg::REG_COEF_TIME, (p == 0) ? 26 : $urandom_range(0, 65535));
      reg_write(fdl_pkg::REG_COEF_FB, $urandom_range(0, 65535));
      reg_write(fdl_pkg::REG_COEF_LP, (p == 4) ? 0 : $urandom_range(0, 65535));
      reg_write(fdl_pkg::REG_COEF_HP, (p == 4) ? 65535 : $urandom_range(0, 65535));
      reg_done();
      if (p == 2) hold_go = 1'b1;
      random_phase(240);
    end

    drain();
    if (mismatches == 0 && expected_out_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
